// File: rtl/bfbp_pkg.sv
package bfbp_pkg;

    localparam int SIZE_W = 16;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;

    localparam logic [SIZE_W-1:0] CAP_RESET = 16'd100;
    localparam logic [CNT_W-1:0]  CNT_MAX   = 7'd127;

    // result status codes
    localparam logic [STAT_W-1:0] ST_PLACED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERSIZE = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_ROOM  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cfg_wr;
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/bfbp_ram.sv
module bfbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bfbp_ctrl.sv
module bfbp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_cfg_valid,
    input  bfbp_pkg::t_sts i_sts,
    output bfbp_pkg::t_cmd o_cmd,
    output logic          o_in_stall,
    output logic          o_cfg_ready
);
    import bfbp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cfg_ready  = 1'b1;
                o_cmd.cfg_wr = i_cfg_valid;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bfbp_dp.sv
module bfbp_dp #(
    parameter int MAX_BINS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bfbp_pkg::t_cmd                      i_cmd,
    output bfbp_pkg::t_sts                      o_sts,
    input  logic [bfbp_pkg::SIZE_W-1:0]         i_cfg_data,
    input  logic [bfbp_pkg::SIZE_W-1:0]         i_item_size,
    input  logic                                i_last_item,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [bfbp_pkg::IDX_W-1:0]          o_bin_index,
    output logic [bfbp_pkg::CNT_W-1:0]          o_bins_used,
    output logic [bfbp_pkg::STAT_W-1:0]         o_status,
    output logic                                o_set_done
);
    import bfbp_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_BINS - 1);

    // configuration and set state
    logic [SIZE_W-1:0] r_cap,   n_cap;
    logic [AW:0]       r_fill,  n_fill;   // bins below this index have been written
    logic [CNT_W-1:0]  r_count, n_count;

    // item and scan state
    logic [SIZE_W-1:0] r_size,  n_size;
    logic              r_last,  n_last;
    logic [AW-1:0]     r_addr,  n_addr;
    logic              r_cmp_vld, n_cmp_vld;
    logic [AW-1:0]     r_cmp_idx, n_cmp_idx;
    logic              r_found, n_found;
    logic [AW-1:0]     r_best_idx, n_best_idx;
    logic [SIZE_W-1:0] r_best_val, n_best_val;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_idx,   n_out_idx;
    logic [CNT_W-1:0]  r_out_cnt,   n_out_cnt;
    logic [STAT_W-1:0] r_out_stat,  n_out_stat;
    logic              r_out_done,  n_out_done;

    logic [SIZE_W-1:0] rd_data;
    logic [SIZE_W-1:0] cand_val;
    logic              oversize;
    logic              placed;
    logic              ram_we;
    logic [SIZE_W-1:0] ram_wdata;
    logic [AW+IDX_W-1:0] best_wide;
    logic [CNT_W-1:0]  cnt_next;
    logic [STAT_W-1:0] stat_next;

    bfbp_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_best_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // unwritten bins read as full capacity
    assign cand_val  = ({1'b0, r_cmp_idx} < r_fill) ? rd_data : r_cap;
    assign oversize  = r_size > r_cap;
    assign placed    = !oversize && r_found;
    assign ram_we    = i_cmd.commit && placed;
    assign ram_wdata = r_best_val - r_size;
    assign best_wide = {{IDX_W{1'b0}}, r_best_idx};

    always_comb begin
        cnt_next = r_count;
        if (placed && r_best_val == r_cap && r_size != '0 && r_count != CNT_MAX) begin
            cnt_next = r_count + 1'b1;
        end
        if (oversize) begin
            stat_next = ST_OVERSIZE;
        end else if (!r_found) begin
            stat_next = ST_NO_ROOM;
        end else begin
            stat_next = ST_PLACED;
        end
    end

    always_comb begin
        n_cap       = r_cap;
        n_fill      = r_fill;
        n_count     = r_count;
        n_size      = r_size;
        n_last      = r_last;
        n_addr      = r_addr;
        n_cmp_vld   = i_cmd.scan;
        n_cmp_idx   = r_addr;
        n_found     = r_found;
        n_best_idx  = r_best_idx;
        n_best_val  = r_best_val;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx   = r_out_idx;
        n_out_cnt   = r_out_cnt;
        n_out_stat  = r_out_stat;
        n_out_done  = r_out_done;

        if (i_cmd.cfg_wr) begin
            n_cap   = i_cfg_data;
            n_fill  = '0;
            n_count = '0;
        end

        if (i_cmd.start) begin
            n_size  = i_item_size;
            n_last  = i_last_item;
            n_addr  = '0;
            n_found = 1'b0;
        end

        if (i_cmd.scan && r_addr != ADDR_LAST) begin
            n_addr = r_addr + 1'b1;
        end

        // strict less-than keeps the lowest index on ties
        if (r_cmp_vld && cand_val >= r_size && (!r_found || cand_val < r_best_val)) begin
            n_found    = 1'b1;
            n_best_idx = r_cmp_idx;
            n_best_val = cand_val;
        end

        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
            n_out_idx   = placed ? best_wide[IDX_W-1:0] : '0;
            n_out_cnt   = cnt_next;
            n_out_stat  = stat_next;
            n_out_done  = r_last;
            n_count     = cnt_next;
            if (placed && {1'b0, r_best_idx} == r_fill) begin
                n_fill = r_fill + 1'b1;
            end
            if (r_last) begin
                n_fill  = '0;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_fill      <= '0;
            r_count     <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap       <= n_cap;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_last     <= n_last;
        r_addr     <= n_addr;
        r_cmp_idx  <= n_cmp_idx;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_out_idx  <= n_out_idx;
        r_out_cnt  <= n_out_cnt;
        r_out_stat <= n_out_stat;
        r_out_done <= n_out_done;
    end

    assign o_sts.scan_last = r_addr == ADDR_LAST;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_out_idx;
    assign o_bins_used = r_out_cnt;
    assign o_status    = r_out_stat;
    assign o_set_done  = r_out_done;

endmodule

// File: rtl/best_fit_bin_packer.sv
// channel   direction  handshake                  payload
// item      in         i_in_valid / o_in_stall    i_item_size, i_last_item
// result    out        o_out_valid / i_out_stall  o_bin_index, o_bins_used, o_status, o_set_done
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (bin capacity)
//
// for each item the capacity table is read one bin a cycle through the single
// read port of the bin ram, then a drain state covers the last ram read, then
// the write-back and result load
// reset is synchronous; afterwards capacity is 100 and the set is empty, with no
// clearing pass: a fill count marks which bins have been written
// a waiting result sits in the output register, so the next word is taken while
// the result is stalled; the write-back waits only if that register is still full
module best_fit_bin_packer #(
    parameter int MAX_BINS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bfbp_pkg::SIZE_W-1:0]    i_item_size,
    input  logic                           i_last_item,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bfbp_pkg::IDX_W-1:0]     o_bin_index,
    output logic [bfbp_pkg::CNT_W-1:0]     o_bins_used,
    output logic [bfbp_pkg::STAT_W-1:0]    o_status,
    output logic                           o_set_done,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bfbp_pkg::SIZE_W-1:0]    i_cfg_data
);
    import bfbp_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: idle, scan of all bins, drain of the ram read, write-back
    bfbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // bin table, best-fit compare, counters and output register
    bfbp_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_data  (i_cfg_data),
        .i_item_size (i_item_size),
        .i_last_item (i_last_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_bin_index (o_bin_index),
        .o_bins_used (o_bins_used),
        .o_status    (o_status),
        .o_set_done  (o_set_done)
    );

    // a new word starts a scan, so the next cycle is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item accepted while a scan was starting");

    // rejected items never report a bin
    a_index_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_PLACED) |-> (o_bin_index == '0))
        else $error("bin index set on a rejected item");

    // only bins that exist can be open
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_bins_used) <= 32'(MAX_BINS)))
        else $error("bin count above bin total");

endmodule
